FILE: design/wcse_pkg.sv
// Shared types and constants for the custom section extractor.
// Used by the parser, the result queue and the top level; no dependencies.
package wcse_pkg;

	localparam int MAX_NAME_LEN  = 8;
	localparam int SIZE_WIDTH    = 32;
	localparam int HEADER_LEN    = 8;
	localparam int LEB_MAX_BYTES = 10;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

	// configuration register indexes
	localparam logic CFG_NAME_LEN   = 1'b0;
	localparam logic CFG_NAME_BYTES = 1'b1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_FOUND     = 2'd1,
		KIND_NOT_FOUND = 2'd2,
		KIND_MALFORMED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ID      = 3'd1,
		PH_SIZE    = 3'd2,
		PH_NAMELEN = 3'd3,
		PH_NAME    = 3'd4,
		PH_SKIP    = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		LEB_MORE = 2'd0,
		LEB_DONE = 2'd1,
		LEB_ERR  = 2'd2
	} leb_status_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		kind_t       kind;
		logic [31:0] payload_length;
		logic        run_end;
	} result_t;

	// results produced by one parsed byte, in delivery order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

FILE: design/wcse_parser.sv
// Input stage and byte-wise section parser of the custom section extractor.
// Depends on wcse_pkg; pushes its results into the result queue.
module wcse_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 module_byte,
	input  logic                       module_end,
	input  logic [3:0]                 wanted_name_length,
	input  logic [63:0]                wanted_name_bytes,
	input  logic                       queue_room,
	output wcse_pkg::push_t            push
);
	import wcse_pkg::*;

	typedef struct packed {
		leb_status_t           status;
		logic [SIZE_WIDTH-1:0] value;
		logic [3:0]            count;
	} leb_res_t;

	function automatic leb_res_t leb_take(input logic [7:0] c,
		input logic [SIZE_WIDTH-1:0] value, input logic [3:0] count);
		leb_res_t   r;
		logic [6:0] bits;
		logic [5:0] shamt;
		logic [63:0] v;
		logic       ovf;
		bits  = c[6:0];
		shamt = 6'(count) * 6'd7;
		v     = 64'(bits) << shamt;
		if (32'(shamt) < SIZE_WIDTH) begin
			ovf = (v >> SIZE_WIDTH) != 64'd0;
		end else begin
			ovf = bits != 7'd0;
		end
		r.value  = value | v[SIZE_WIDTH-1:0];
		r.count  = count + 4'd1;
		if (ovf) begin
			r.status = LEB_ERR;
		end else if (!c[7]) begin
			r.status = LEB_DONE;
		end else if (32'(r.count) >= LEB_MAX_BYTES) begin
			r.status = LEB_ERR;
		end else begin
			r.status = LEB_MORE;
		end
		return r;
	endfunction

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       accept;
	logic       advance;

	// parse state
	phase_t                phase_q, phase_d;
	logic [2:0]            hdr_cnt_q, hdr_cnt_d;
	logic [SIZE_WIDTH-1:0] leb_val_q, leb_val_d;
	logic [3:0]            leb_cnt_q, leb_cnt_d;
	logic [SIZE_WIDTH-1:0] remain_q, remain_d;
	logic [3:0]            name_idx_q, name_idx_d;
	logic                  matching_q, matching_d;
	kind_t                 outcome_q, outcome_d;
	logic [31:0]           emitted_q, emitted_d;
	logic                  custom_q, custom_d;

	leb_res_t              leb;
	logic [SIZE_WIDTH-1:0] remain_dec;
	logic [3:0]            idx_inc;
	logic                  byte_bad;
	kind_t                 end_kind;

	assign in_stall = valid_s1 && !queue_room;
	assign accept   = in_valid && !in_stall;
	assign advance  = valid_s1 && queue_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= module_byte;
			end_s1  <= module_end;
		end
	end

	assign leb        = leb_take(byte_s1, leb_val_q, leb_cnt_q);
	assign remain_dec = remain_q - SIZE_WIDTH'(1);
	assign idx_inc    = name_idx_q + 4'd1;
	assign byte_bad   = (32'(name_idx_q) >= MAX_NAME_LEN) || (name_idx_q >= wanted_name_length)
		|| (wanted_name_bytes[name_idx_q[2:0]*8 +: 8] != byte_s1);

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		leb_val_d  = leb_val_q;
		leb_cnt_d  = leb_cnt_q;
		remain_d   = remain_q;
		name_idx_d = name_idx_q;
		matching_d = matching_q;
		outcome_d  = outcome_q;
		emitted_d  = emitted_q;
		custom_d   = custom_q;
		push       = '0;
		end_kind   = KIND_NOT_FOUND;

		case (phase_q)
			PH_HEADER: begin
				if (32'(hdr_cnt_q) >= HEADER_LEN - 1) begin
					phase_d = PH_ID;
				end else begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end
			end
			PH_ID: begin
				custom_d  = byte_s1 == 8'd0;
				leb_val_d = '0;
				leb_cnt_d = '0;
				phase_d   = PH_SIZE;
			end
			PH_SIZE: begin
				leb_val_d = leb.value;
				leb_cnt_d = leb.count;
				case (leb.status)
					LEB_ERR: begin
						outcome_d = KIND_MALFORMED;
						phase_d   = PH_DONE;
					end
					LEB_DONE: begin
						remain_d = leb.value;
						if (custom_q) begin
							if (leb.value == '0) begin
								outcome_d = KIND_MALFORMED;
								phase_d   = PH_DONE;
							end else begin
								leb_val_d = '0;
								leb_cnt_d = '0;
								phase_d   = PH_NAMELEN;
							end
						end else begin
							phase_d = (leb.value == '0) ? PH_ID : PH_SKIP;
						end
					end
					default: begin
					end
				endcase
			end
			PH_NAMELEN: begin
				remain_d  = remain_dec;
				leb_val_d = leb.value;
				leb_cnt_d = leb.count;
				case (leb.status)
					LEB_ERR: begin
						outcome_d = KIND_MALFORMED;
						phase_d   = PH_DONE;
					end
					LEB_MORE: begin
						if (remain_dec == '0) begin
							outcome_d = KIND_MALFORMED;
							phase_d   = PH_DONE;
						end
					end
					default: begin
						if (leb.value > remain_dec) begin
							outcome_d = KIND_MALFORMED;
							phase_d   = PH_DONE;
						end else if (leb.value == SIZE_WIDTH'(wanted_name_length)
							&& 32'(wanted_name_length) <= MAX_NAME_LEN) begin
							name_idx_d = '0;
							matching_d = 1'b1;
							if (leb.value == '0) begin
								// empty name matches an empty wanted name
								if (remain_dec == '0) begin
									outcome_d = KIND_FOUND;
									phase_d   = PH_DONE;
								end else begin
									phase_d = PH_PAYLOAD;
								end
							end else begin
								phase_d = PH_NAME;
							end
						end else begin
							phase_d = (remain_dec == '0) ? PH_ID : PH_SKIP;
						end
					end
				endcase
			end
			PH_NAME: begin
				matching_d = matching_q && !byte_bad;
				name_idx_d = idx_inc;
				remain_d   = remain_dec;
				if (idx_inc >= wanted_name_length || remain_dec == '0) begin
					if (matching_d && idx_inc >= wanted_name_length) begin
						if (remain_dec == '0) begin
							outcome_d = KIND_FOUND;
							phase_d   = PH_DONE;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end else begin
						phase_d = (remain_dec == '0) ? PH_ID : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					phase_d = PH_ID;
				end
			end
			PH_PAYLOAD: begin
				push.count                = 2'd1;
				push.first.payload_byte   = byte_s1;
				push.first.kind           = KIND_PAYLOAD;
				push.first.payload_length = 32'd0;
				push.first.run_end        = !end_s1;
				emitted_d = emitted_q + 32'd1;
				remain_d  = remain_dec;
				if (remain_dec == '0) begin
					outcome_d = KIND_FOUND;
					phase_d   = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		if (end_s1) begin
			case (phase_d)
				PH_DONE:                   end_kind = outcome_d;
				PH_HEADER, PH_ID, PH_SKIP: end_kind = KIND_NOT_FOUND;
				default:                   end_kind = KIND_MALFORMED;
			endcase
			if (push.count == 2'd0) begin
				push.count                = 2'd1;
				push.first.payload_byte   = 8'd0;
				push.first.kind           = end_kind;
				push.first.payload_length = emitted_d;
				push.first.run_end        = 1'b1;
			end else begin
				push.count                 = 2'd2;
				push.second.payload_byte   = 8'd0;
				push.second.kind           = end_kind;
				push.second.payload_length = emitted_d;
				push.second.run_end        = 1'b1;
			end
			// start over for the next module
			phase_d    = PH_HEADER;
			hdr_cnt_d  = '0;
			leb_val_d  = '0;
			leb_cnt_d  = '0;
			remain_d   = '0;
			name_idx_d = '0;
			matching_d = 1'b1;
			outcome_d  = KIND_NOT_FOUND;
			emitted_d  = '0;
			custom_d   = 1'b0;
		end

		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			leb_val_q  <= '0;
			leb_cnt_q  <= '0;
			remain_q   <= '0;
			name_idx_q <= '0;
			matching_q <= 1'b1;
			outcome_q  <= KIND_NOT_FOUND;
			emitted_q  <= '0;
			custom_q   <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			leb_val_q  <= leb_val_d;
			leb_cnt_q  <= leb_cnt_d;
			remain_q   <= remain_d;
			name_idx_q <= name_idx_d;
			matching_q <= matching_d;
			outcome_q  <= outcome_d;
			emitted_q  <= emitted_d;
			custom_q   <= custom_d;
		end
	end

endmodule

FILE: design/wcse_result_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one unless stalled.
// Depends on wcse_pkg.
module wcse_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  wcse_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output wcse_pkg::result_t   head
);
	import wcse_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	// leave space for the two results one byte can cause
	assign room      = 32'(count_q) <= FIFO_DEPTH - 2;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

FILE: design/wasm_custom_section_extract_core.sv
// Top level of the WebAssembly custom section extractor.
// Depends on wcse_pkg, wcse_parser and wcse_result_fifo.
//
// Usage:
//   Feed the module one byte per request on the input channel (module_byte,
//   with module_end set on the final byte). Results come out on the output
//   channel: one request per payload byte of the first custom section whose
//   name matches, then one status request (found, not found, malformed) with
//   the payload length on the byte marked module_end. run_end marks the last
//   result caused by one input byte.
//   Program the wanted name through the write port while the block is idle:
//   index CFG_NAME_LEN takes the name length, CFG_NAME_BYTES the name bytes,
//   first byte in the low octet.
// Timing:
//   A byte is taken into the input register, parsed from there and its results
//   land in a four-entry queue; the first result passes through the input
//   register and the queue before it can be taken. One byte is accepted per
//   cycle; the input stalls only while the queue lacks room for two results,
//   which only the end byte of a module that ends inside a payload causes.
// Reset:
//   arst_n clears the parser to the header phase, empties the queue and
//   clears the name registers. A stall on the output side holds the queue
//   head and, once more than two results wait, backs up to the input stall.
module wasm_custom_section_extract_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  module_byte,
	input  logic        module_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic [1:0]  result_kind,
	output logic [31:0] payload_length,
	output logic        run_end,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata
);
	import wcse_pkg::*;

	logic [3:0]  name_len_q;
	logic [63:0] name_bytes_q;
	push_t       push;
	logic        queue_room;
	result_t     head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q   <= '0;
			name_bytes_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NAME_LEN:   name_len_q   <= cfg_wdata[3:0];
				CFG_NAME_BYTES: name_bytes_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	wcse_parser u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.module_byte        (module_byte),
		.module_end         (module_end),
		.wanted_name_length (name_len_q),
		.wanted_name_bytes  (name_bytes_q),
		.queue_room         (queue_room),
		.push               (push)
	);

	wcse_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (queue_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// drive the result fields from the queue head
	assign payload_byte   = head.payload_byte;
	assign result_kind    = head.kind;
	assign payload_length = head.payload_length;
	assign run_end        = head.run_end;

endmodule
